// File: rtl/huffman_table_encoder_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// huffman table encoder bit packer assertion macros
// shared concurrent check forms; clk and rst_n come from the enclosing scope
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_BIT_PACKER_ASSERT_SVH

// same-cycle implication
`define HTEBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htebp: same-cycle check failed");

// next-cycle implication
`define HTEBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htebp: next-cycle check failed");

`endif

// File: rtl/htebp_pkg.sv
// ---------------------------------------------------------------------------
// htebp_pkg
// shared types and constants of the huffman table encoder bit packer
// ---------------------------------------------------------------------------
package htebp_pkg;

  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned SYMBOL_COUNT_DEF = 256;
  localparam int unsigned CODE_W           = 32;
  localparam int unsigned CAP_W            = 21;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 21'd1048576;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCODE  = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [19:0] byte_position;
    status_t     status;
    logic [20:0] total_bytes;
    logic        last;
  } out_t;

  // stream state carried between requests
  typedef struct packed {
    logic [7:0]       pend_byte;
    logic [2:0]       pend_cnt;
    logic [CAP_W-1:0] wpos;
    logic             ovf;
  } state_t;

endpackage

// File: rtl/htebp_ram.sv
// ---------------------------------------------------------------------------
// htebp_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module htebp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/htebp_pack.sv
// ---------------------------------------------------------------------------
// htebp_pack
// msb-first bit packer: merges a code word into the pending byte, splits out
// the completed bytes and checks them against the output capacity
// ---------------------------------------------------------------------------
module htebp_pack #(
  parameter int unsigned MAX_CODE_LEN = htebp_pkg::MAX_CODE_LEN_DEF
) (
  input  htebp_pkg::opcode_t                 op,
  input  logic                               hit,
  input  logic [htebp_pkg::CODE_W-1:0]       code,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]  len,
  input  htebp_pkg::state_t                  st,
  input  logic [htebp_pkg::CAP_W-1:0]        cap,
  output htebp_pkg::state_t                  st_nxt,
  output htebp_pkg::out_t                    res [(MAX_CODE_LEN + 7) / 8],
  output logic [$clog2((MAX_CODE_LEN + 7) / 8 + 1)-1:0] res_cnt
);

  localparam int unsigned NB    = (MAX_CODE_LEN + 7) / 8;
  localparam int unsigned CNT_W = $clog2(NB + 1);
  localparam int unsigned AW    = 8 * (NB + 1);
  localparam int unsigned SHW   = $clog2(AW + 1);
  localparam int unsigned TW    = $clog2(MAX_CODE_LEN + 8);
  localparam int unsigned NFW   = TW - 3;
  localparam int unsigned CAP_W = htebp_pkg::CAP_W;

  logic [AW-1:0]    code_w;
  logic [AW-1:0]    mask;
  logic [AW-1:0]    acc;
  logic [AW-1:0]    rest;
  logic [SHW-1:0]   sh;
  logic [TW-1:0]    tot;
  logic [NFW-1:0]   nf;
  logic [NFW-1:0]   nemit;
  logic [CAP_W-1:0] avail;
  logic             ovf_hit;
  logic [7:0]       bytes [NB];

  // merged bit window: pending bits on top, code right behind them
  always_comb begin
    code_w  = AW'(code);
    mask    = ~({AW{1'b1}} << len);
    sh      = SHW'(AW) - SHW'(st.pend_cnt) - SHW'(len);
    acc     = {st.pend_byte, {(AW-8){1'b0}}} | ((code_w & mask) << sh);
    tot     = TW'(st.pend_cnt) + TW'(len);
    nf      = tot[TW-1:3];
    rest    = acc << {nf, 3'b000};
    avail   = (cap > st.wpos) ? (cap - st.wpos) : '0;
    ovf_hit = CAP_W'(nf) > avail;
    nemit   = ovf_hit ? avail[NFW-1:0] : nf;
    for (int i = 0; i < NB; i++) begin
      bytes[i] = acc[AW-1-8*i -: 8];
    end
  end

  always_comb begin
    st_nxt  = st;
    res_cnt = CNT_W'(1);
    for (int i = 0; i < NB; i++) begin
      res[i]        = '0;
      res[i].status = htebp_pkg::ST_OK;
    end

    unique case (op)
      htebp_pkg::OP_LOAD: begin
        res[0].last = 1'b1;
      end

      htebp_pkg::OP_RESTART: begin
        st_nxt      = '0;
        res[0].last = 1'b1;
      end

      htebp_pkg::OP_FLUSH: begin
        res[0].last        = 1'b1;
        res[0].total_bytes = st.wpos;
        if (st.ovf) begin
          res[0].status = htebp_pkg::ST_OVERFLOW;
        end else if (st.pend_cnt != '0) begin
          st_nxt.pend_byte = '0;
          st_nxt.pend_cnt  = '0;
          if (avail == '0) begin
            st_nxt.ovf    = 1'b1;
            res[0].status = htebp_pkg::ST_OVERFLOW;
          end else begin
            st_nxt.wpos          = st.wpos + CAP_W'(1);
            res[0].byte_valid    = 1'b1;
            res[0].out_byte      = st.pend_byte;
            res[0].byte_position = st.wpos[19:0];
            res[0].total_bytes   = st.wpos + CAP_W'(1);
          end
        end
      end

      htebp_pkg::OP_ENCODE: begin
        if (st.ovf) begin
          res[0].status = htebp_pkg::ST_OVERFLOW;
          res[0].last   = 1'b1;
        end else if (!hit || len == '0) begin
          res[0].status = htebp_pkg::ST_INVALID;
          res[0].last   = 1'b1;
        end else begin
          for (int i = 0; i < NB; i++) begin
            if (NFW'(i) < nemit) begin
              res[i].byte_valid    = 1'b1;
              res[i].out_byte      = bytes[i];
              res[i].byte_position = 20'(st.wpos + CAP_W'(i));
            end else if (ovf_hit && NFW'(i) == nemit) begin
              res[i].status = htebp_pkg::ST_OVERFLOW;
              res[i].last   = 1'b1;
            end
            if (!ovf_hit && nf != '0 && NFW'(i) == nf - NFW'(1)) begin
              res[i].last = 1'b1;
            end
          end
          // no byte completed: a single empty result
          if (!ovf_hit && nf == '0) begin
            res[0].last = 1'b1;
          end
          st_nxt.wpos = st.wpos + CAP_W'(nemit);
          if (ovf_hit) begin
            st_nxt.ovf       = 1'b1;
            st_nxt.pend_byte = '0;
            st_nxt.pend_cnt  = '0;
            res_cnt          = CNT_W'(nemit) + CNT_W'(1);
          end else begin
            st_nxt.pend_byte = rest[AW-1 -: 8];
            st_nxt.pend_cnt  = tot[2:0];
            res_cnt          = (nf == '0) ? CNT_W'(1) : CNT_W'(nf);
          end
        end
      end

      default: begin
        res[0].last = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/huffman_table_encoder_bit_packer.sv
// ---------------------------------------------------------------------------
// huffman table encoder bit packer
// loadable per-symbol code table feeding an msb-first byte packer with
// capacity check, sticky overflow and stream restart
// ---------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid / in_stall    htebp_pkg::in_t (one request)
// out      out  out_valid / out_stall  htebp_pkg::out_t (one result)
// cfg      in   cfg_wr_en              cfg_wr_data (out_capacity)
//
// a request enters every cycle unless stalled; via input reg, then result bank
// an encode that completes n bytes puts n results on the one-byte result port
// (up to (MAX_CODE_LEN + 7) / 8), so that port sets the sustained rate
// table ram is read at accept; reset clears the per-symbol valid flags at once
// out_stall backs up through the result bank and the input register
// ---------------------------------------------------------------------------
module huffman_table_encoder_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = htebp_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned SYMBOL_COUNT = htebp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  htebp_pkg::in_t              in_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output htebp_pkg::out_t             out_payload,
  input  logic                        cfg_wr_en,
  input  logic [htebp_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int unsigned NB     = (MAX_CODE_LEN + 7) / 8;
  localparam int unsigned LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned CNT_W  = $clog2(NB + 1);
  localparam int unsigned SYM_W  = $clog2(SYMBOL_COUNT);
  localparam int unsigned CODE_W = htebp_pkg::CODE_W;
  localparam int unsigned ENT_W  = CODE_W + LEN_W;

  logic                        in_acc;
  logic                        out_acc;
  logic                        b_take;
  logic                        sym_ok;
  logic [SYM_W-1:0]            sym_idx;
  logic [LEN_W-1:0]            len_sat;
  logic                        tbl_we;
  logic [ENT_W-1:0]            tbl_rd;

  logic [SYMBOL_COUNT-1:0]     tbl_vld_r, tbl_vld_nxt;
  logic [htebp_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                        a_valid_r, a_valid_nxt;
  htebp_pkg::in_t              a_r;
  logic                        a_hit_r;
  htebp_pkg::state_t           st_r, st_nxt;
  htebp_pkg::out_t             res_r [NB];
  htebp_pkg::out_t             res_nxt [NB];
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  htebp_pkg::state_t           pk_st;
  htebp_pkg::out_t             pk_res [NB];
  logic [CNT_W-1:0]            pk_cnt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // packer takes the held request when the result bank is empty or drains now
  assign b_take   = a_valid_r && (cnt_r == '0 || (cnt_r == CNT_W'(1) && out_acc));
  assign in_stall = a_valid_r && !b_take;

  assign out_valid   = cnt_r != '0;
  assign out_payload = res_r[0];

  assign sym_ok  = {1'b0, in_payload.symbol} < 9'(SYMBOL_COUNT);
  assign sym_idx = in_payload.symbol[SYM_W-1:0];
  assign len_sat = (8'(in_payload.code_length) > 8'(MAX_CODE_LEN)) ?
                   LEN_W'(MAX_CODE_LEN) : LEN_W'(in_payload.code_length);
  assign tbl_we  = in_acc && in_payload.opcode == htebp_pkg::OP_LOAD && sym_ok;

  htebp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (sym_idx),
    .wr_data ({in_payload.code_bits, len_sat}),
    .rd_en   (in_acc),
    .rd_addr (sym_idx),
    .rd_data (tbl_rd)
  );

  htebp_pack #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_pack (
    .op      (a_r.opcode),
    .hit     (a_hit_r),
    .code    (tbl_rd[ENT_W-1:LEN_W]),
    .len     (tbl_rd[LEN_W-1:0]),
    .st      (st_r),
    .cap     (cap_r),
    .st_nxt  (pk_st),
    .res     (pk_res),
    .res_cnt (pk_cnt)
  );

  always_comb begin
    tbl_vld_nxt = tbl_vld_r;
    if (tbl_we) begin
      tbl_vld_nxt[sym_idx] = 1'b1;
    end
    cap_nxt     = cfg_wr_en ? cfg_wr_data : cap_r;
    a_valid_nxt = in_acc ? 1'b1 : (b_take ? 1'b0 : a_valid_r);
    st_nxt      = b_take ? pk_st : st_r;
  end

  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (b_take) begin
      res_nxt = pk_res;
      cnt_nxt = pk_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < NB - 1; i++) begin
        res_nxt[i] = res_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      cap_r     <= htebp_pkg::CAPACITY_RESET;
      a_valid_r <= 1'b0;
      st_r      <= '0;
      cnt_r     <= '0;
    end else begin
      tbl_vld_r <= tbl_vld_nxt;
      cap_r     <= cap_nxt;
      a_valid_r <= a_valid_nxt;
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r     <= in_payload;
      a_hit_r <= sym_ok && tbl_vld_r[sym_idx];
    end
    res_r <= res_nxt;
  end

endmodule

// File: rtl/htebp_checker.sv
// ---------------------------------------------------------------------------
// htebp_checker
// port-level checks on the huffman table encoder bit packer
// ---------------------------------------------------------------------------
module htebp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input htebp_pkg::out_t out_payload
);

`include "huffman_table_encoder_bit_packer_assert.svh"

  logic err_res;
  logic err_end;

  assign err_res = out_valid && out_payload.status != htebp_pkg::ST_OK;
  assign err_end = out_payload.last && !out_payload.byte_valid;

  `HTEBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

  // an empty result bank always lets the held request through
  `HTEBP_ASSERT_NOW(a_in_free, !out_valid, !in_stall)

  // results of one request leave back to back
  `HTEBP_ASSERT_NEXT(a_burst, out_valid && !out_stall && !out_payload.last, out_valid)

  // error results end their request and carry no byte
  `HTEBP_ASSERT_NOW(a_err_last, err_res, err_end)

endmodule

bind huffman_table_encoder_bit_packer htebp_checker u_htebp_checker (.*);

// File: tb/tb_huffman_table_encoder_bit_packer.sv
// ---------------------------------------------------------------------------
// tb_huffman_table_encoder_bit_packer
// drives table loads, encodes, flushes and restarts into the huffman packer,
// predicts every emitted byte and status in a local copy of the table and
// stream state, and checks each result in order against that prediction
// ---------------------------------------------------------------------------
module tb_huffman_table_encoder_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  htebp_pkg::in_t              in_payload;
  logic                        out_valid;
  logic                        out_stall;
  htebp_pkg::out_t             out_payload;
  logic                        cfg_wr_en;
  logic [htebp_pkg::CAP_W-1:0] cfg_wr_data;

  huffman_table_encoder_bit_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // local copy of the code table and stream state
  logic [31:0]                 tbl_code [htebp_pkg::SYMBOL_COUNT_DEF];
  logic [5:0]                  tbl_len  [htebp_pkg::SYMBOL_COUNT_DEF];
  logic [7:0]                  pk_byte;
  int                          pk_bits;
  logic [htebp_pkg::CAP_W-1:0] wr_pos;
  logic                        ovf_flag;
  logic [htebp_pkg::CAP_W-1:0] cap_reg;

  htebp_pkg::out_t packer_out_q[$];
  logic [7:0]      live_syms[$];
  bit              idle_on;
  int              err_count;
  int              cycle_count;
  int              n_requests;
  int              n_bytes;
  int              n_overflow;
  int              n_invalid;
  int              n_cap_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, packer_out_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 23);
  end

  function automatic void push_result(logic v, logic [7:0] b, logic [19:0] pos,
                                      htebp_pkg::status_t st, logic [20:0] tot);
    htebp_pkg::out_t r;
    r = '0;
    r.byte_valid    = v;
    r.out_byte      = b;
    r.byte_position = pos;
    r.status        = st;
    r.total_bytes   = tot;
    r.last          = 1'b0;
    packer_out_q.push_back(r);
  endfunction

  // store the completed pending byte or record the overflow
  function automatic void emit_byte(bit is_flush);
    logic [19:0] pos;
    if (wr_pos >= cap_reg) begin
      ovf_flag = 1'b1;
      pk_byte  = '0;
      pk_bits  = 0;
      push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OVERFLOW, is_flush ? wr_pos : '0);
    end else begin
      pos    = wr_pos[19:0];
      wr_pos = wr_pos + 21'd1;
      push_result(1'b1, pk_byte, pos, htebp_pkg::ST_OK, is_flush ? wr_pos : '0);
      pk_byte = '0;
      pk_bits = 0;
    end
  endfunction

  function automatic void apply_request(htebp_pkg::in_t req);
    int              first;
    int              len;
    htebp_pkg::out_t tail;
    first = packer_out_q.size();
    case (req.opcode)
      htebp_pkg::OP_LOAD: begin
        tbl_code[req.symbol] = req.code_bits;
        tbl_len[req.symbol]  = (req.code_length > htebp_pkg::MAX_CODE_LEN_DEF) ?
                               6'(htebp_pkg::MAX_CODE_LEN_DEF) : req.code_length;
        push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OK, '0);
      end
      htebp_pkg::OP_ENCODE: begin
        len = int'(tbl_len[req.symbol]);
        if (ovf_flag) begin
          push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OVERFLOW, '0);
        end else if (len == 0) begin
          push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_INVALID, '0);
        end else begin
          // msb of the code word goes out first
          for (int i = len - 1; i >= 0 && !ovf_flag; i--) begin
            if (tbl_code[req.symbol][i]) pk_byte[7 - pk_bits] = 1'b1;
            pk_bits++;
            if (pk_bits == 8) emit_byte(1'b0);
          end
          if (packer_out_q.size() == first) begin
            push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OK, '0);
          end
        end
      end
      htebp_pkg::OP_FLUSH: begin
        if (ovf_flag) push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OVERFLOW, wr_pos);
        else if (pk_bits > 0) emit_byte(1'b1);
        else push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OK, wr_pos);
      end
      default: begin
        pk_byte  = '0;
        pk_bits  = 0;
        wr_pos   = '0;
        ovf_flag = 1'b0;
        push_result(1'b0, 8'd0, 20'd0, htebp_pkg::ST_OK, '0);
      end
    endcase
    tail = packer_out_q.pop_back();
    tail.last = 1'b1;
    packer_out_q.push_back(tail);
  endfunction

  function automatic htebp_pkg::in_t make_req(htebp_pkg::opcode_t op, logic [7:0] sym,
                                              logic [31:0] bits, logic [5:0] len);
    htebp_pkg::in_t r;
    r.opcode      = op;
    r.symbol      = sym;
    r.code_bits   = bits;
    r.code_length = len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    htebp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (packer_out_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got %h",
                 $time, out_payload);
        err_count++;
      end else begin
        want = packer_out_q.pop_front();
        check_field("byte_valid", 32'(want.byte_valid), 32'(out_payload.byte_valid));
        check_field("out_byte", 32'(want.out_byte), 32'(out_payload.out_byte));
        check_field("byte_position", 32'(want.byte_position),
                    32'(out_payload.byte_position));
        check_field("status", 32'(want.status), 32'(out_payload.status));
        check_field("total_bytes", 32'(want.total_bytes), 32'(out_payload.total_bytes));
        check_field("last", 32'(want.last), 32'(out_payload.last));
        if (want.byte_valid) n_bytes++;
        if (want.status == htebp_pkg::ST_OVERFLOW) n_overflow++;
        if (want.status == htebp_pkg::ST_INVALID) n_invalid++;
      end
    end
  end

  task automatic send_request(htebp_pkg::in_t req);
    if (idle_on && $urandom_range(99) < 23) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (in_stall);
    apply_request(req);
    n_requests++;
    if (req.opcode == htebp_pkg::OP_LOAD && req.code_length != 0) begin
      live_syms.push_back(req.symbol);
    end
  endtask

  // drop valid and let the pipeline empty out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (packer_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [htebp_pkg::CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
    n_cap_writes++;
  endtask

  task automatic test_table_and_packing();
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));   // never loaded
    send_request(make_req(htebp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
    send_request(make_req(htebp_pkg::OP_LOAD, 8'hFF, 32'h0000_0000, 6'd1));
    send_request(make_req(htebp_pkg::OP_LOAD, 8'h5A, 32'h0000_0055, 6'd7));
    send_request(make_req(htebp_pkg::OP_LOAD, 8'hA5, 32'hDEAD_BEEF, 6'd63)); // saturates
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'hFF, '0, '0));
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h5A, '0, '0));
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'hA5, '0, '0));
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
    send_request(make_req(htebp_pkg::OP_FLUSH, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_FLUSH, 8'hFF, '0, '0));
    send_request(make_req(htebp_pkg::OP_LOAD, 8'h5A, 32'h1234_5678, 6'd0)); // invalidate
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h5A, '0, '0));
    send_request(make_req(htebp_pkg::OP_RESTART, 8'h00, '0, '0));
  endtask

  task automatic test_overflow();
    write_capacity(21'd2);
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));  // third byte overflows
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h5A, '0, '0));  // overflow beats invalid
    send_request(make_req(htebp_pkg::OP_FLUSH, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_RESTART, 8'h00, '0, '0));
    write_capacity(21'd0);
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'hFF, '0, '0));
    send_request(make_req(htebp_pkg::OP_FLUSH, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_RESTART, 8'h00, '0, '0));
    write_capacity(htebp_pkg::CAPACITY_RESET);
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));
    // capacity drops below the write position
    write_capacity(21'd1);
    send_request(make_req(htebp_pkg::OP_ENCODE, 8'h00, '0, '0));
    send_request(make_req(htebp_pkg::OP_RESTART, 8'h00, '0, '0));
  endtask

  task automatic send_random_load();
    logic [5:0] len;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 80) len = 6'($urandom_range(1, 32));
    else if (pick < 90) len = '0;
    else len = 6'($urandom_range(33, 63));
    send_request(make_req(htebp_pkg::OP_LOAD, 8'($urandom), $urandom, len));
  endtask

  task automatic test_random_stream();
    logic [htebp_pkg::CAP_W-1:0] caps[6];
    int                          pick;
    logic [7:0]                  sym;
    caps[0] = htebp_pkg::CAPACITY_RESET;
    caps[1] = 21'($urandom_range(4, 40));
    caps[2] = 21'($urandom_range(100, 5000));
    caps[3] = 21'($urandom_range(1, 12));
    caps[4] = 21'd0;
    caps[5] = htebp_pkg::CAPACITY_RESET;
    repeat (10) send_random_load();
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      idle_on = (ph != 2);
      send_request(make_req(htebp_pkg::OP_RESTART, 8'($urandom), $urandom, 6'($urandom)));
      repeat (48) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_random_load();
        end else if (pick < 80) begin
          if (live_syms.size() != 0 && $urandom_range(99) < 85)
            sym = live_syms[$urandom_range(live_syms.size() - 1)];
          else
            sym = 8'($urandom);
          // encode and flush ignore the load fields, fill them with noise
          send_request(make_req(htebp_pkg::OP_ENCODE, sym, $urandom, 6'($urandom)));
        end else if (pick < 93) begin
          send_request(make_req(htebp_pkg::OP_FLUSH, 8'($urandom), $urandom,
                                6'($urandom)));
        end else begin
          send_request(make_req(htebp_pkg::OP_RESTART, 8'($urandom), $urandom,
                                6'($urandom)));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_payload  = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    idle_on     = 1'b1;
    err_count   = 0;
    cycle_count = 0;
    n_requests  = 0;
    n_bytes     = 0;
    n_overflow  = 0;
    n_invalid   = 0;
    n_cap_writes = 0;
    for (int s = 0; s < htebp_pkg::SYMBOL_COUNT_DEF; s++) begin
      tbl_code[s] = '0;
      tbl_len[s]  = '0;
    end
    pk_byte  = '0;
    pk_bits  = 0;
    wr_pos   = '0;
    ovf_flag = 1'b0;
    cap_reg  = htebp_pkg::CAPACITY_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_table_and_packing();
    test_overflow();
    test_random_stream();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d requests sent over %0d capacity settings", n_requests, n_cap_writes);
    $display("%0d bytes emitted, %0d overflow and %0d invalid-symbol results",
             n_bytes, n_overflow, n_invalid);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
